### rtl/core/wcwd_pkg.sv
// ----------------------------------------------------------------------------
// wcwd_pkg
// Shared types and constants for the wire-chamber readout word decoder.
// ----------------------------------------------------------------------------
package wcwd_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned WidthW  = 4;
  localparam int unsigned StatusW = 3;

  // Bit 15 marks a width word.
  localparam int unsigned WidthFlagBit = 15;
  // First wire number that lies beyond the chamber: 512 logicals * 32 wires.
  localparam logic [WordW-1:0] AddrLimit = 16'(512 * 32);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,  // expect first word of a pair
    PH_WIDTH  = 2'd1,  // width word held
    PH_ADDR   = 2'd2,  // address word held
    PH_UNUSED = 2'd3   // never entered, treated as idle
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_UNUSED_BITS  = 3'd1,
    ST_NO_ADDR      = 3'd2,
    ST_PARITY       = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_HALF_WIDTH1  = 3'd5,
    ST_DUP_MISMATCH = 3'd6
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [WordW-1:0] start;
    logic [WordW-1:0] stop;
    status_e          status;
  } hit_t;

  typedef struct packed {
    logic             has_result;
    phase_e           phase_d;
    logic [WordW-1:0] held_d;
    hit_t             hit;
  } dec_out_t;

endpackage

### rtl/core/wcwd_decode.sv
// ----------------------------------------------------------------------------
// wcwd_decode
// Combinational pair decode: next pairing state and the wire range result.
// ----------------------------------------------------------------------------
module wcwd_decode (
  input  logic [wcwd_pkg::WordW-1:0] word_i,
  input  logic                       block_start_i,
  input  wcwd_pkg::phase_e           phase_i,
  input  logic [wcwd_pkg::WordW-1:0] held_i,
  output wcwd_pkg::dec_out_t         dec_o
);
  import wcwd_pkg::*;

  logic [WordW-1:0]  wire_cur, wire_held;
  logic [WidthW-1:0] width;
  logic [WidthW-2:0] half_sub;
  logic [WordW-1:0]  w_start, w_stop, a_start, a_stop;
  status_e           w_status, a_status;
  logic              first_word;

  // logical*32 + address: the address is the low five bits, so no adder
  assign wire_cur  = {2'b00, word_i[14:6], word_i[5:1]};
  assign wire_held = {2'b00, held_i[14:6], held_i[5:1]};

  assign width    = held_i[WidthW-1:0];
  assign half_sub = (width == '0) ? '0 : 3'((width - 4'd1) >> 1);
  assign w_start  = wire_cur - WordW'(half_sub);
  assign w_stop   = w_start + WordW'(width);
  assign a_start  = wire_held;
  assign a_stop   = wire_held + 16'd1;

  always_comb begin
    if (held_i[14:4] != '0) begin
      w_status = ST_UNUSED_BITS;
    end else if (word_i[WidthFlagBit]) begin
      w_status = ST_NO_ADDR;
    end else if (word_i[0] == width[0]) begin
      w_status = ST_PARITY;
    end else if (w_start >= AddrLimit) begin
      w_status = ST_OUT_OF_RANGE;
    end else begin
      w_status = ST_OK;
    end
  end

  always_comb begin
    if (held_i[0]) begin
      a_status = ST_HALF_WIDTH1;
    end else if (word_i != held_i) begin
      a_status = ST_DUP_MISMATCH;
    end else begin
      a_status = ST_OK;
    end
  end

  assign first_word = block_start_i || (phase_i != PH_WIDTH && phase_i != PH_ADDR);

  always_comb begin
    dec_o = '0;
    dec_o.held_d  = held_i;
    dec_o.phase_d = PH_IDLE;
    if (first_word) begin
      dec_o.held_d  = word_i;
      dec_o.phase_d = word_i[WidthFlagBit] ? PH_WIDTH : PH_ADDR;
    end else if (phase_i == PH_WIDTH) begin
      dec_o.has_result = 1'b1;
      dec_o.hit.status = w_status;
      if (w_status == ST_OK) begin
        dec_o.hit.valid = 1'b1;
        dec_o.hit.start = w_start;
        dec_o.hit.stop  = w_stop;
      end
    end else begin
      dec_o.has_result = 1'b1;
      dec_o.hit.status = a_status;
      if (a_status == ST_OK || a_status == ST_DUP_MISMATCH) begin
        dec_o.hit.valid = 1'b1;
        dec_o.hit.start = a_start;
        dec_o.hit.stop  = a_stop;
      end
    end
  end

endmodule

### rtl/core/wire_chamber_word_decoder.sv
// ----------------------------------------------------------------------------
// wire_chamber_word_decoder
// Pairs 16-bit chamber readout words and emits one fired-wire range per pair.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one readout word per
//   transaction, with block_start_i set on the first word of an event block.
//   Output channel (out_valid_o/out_ready_i) carries one result transaction
//   for the second word of each pair: hit_valid_o, hit_start_o, hit_end_o
//   (one past the last wire) and status_o. First words give no result.
//   Timing: the second word of a pair lands in the input register when it is
//   accepted and is decoded into the result register once that register is
//   free.
//   Throughput: one word per cycle unless stalled; decode is one shallow pass.
//   Stall: while a result waits in the output register, the input register
//   still moves on words that give no result; a word that needs the output
//   register holds, and in_ready_o drops only once both registers are full.
//   Reset: clears the valid bits and the pairing state back to "expect the
//   first word of a pair", with the held word at zero.
// ----------------------------------------------------------------------------
module wire_chamber_word_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wcwd_pkg::WordW-1:0]   data_word_i,
  input  logic                         block_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_valid_o,
  output logic [wcwd_pkg::WordW-1:0]   hit_start_o,
  output logic [wcwd_pkg::WordW-1:0]   hit_end_o,
  output logic [wcwd_pkg::StatusW-1:0] status_o
);
  import wcwd_pkg::*;

  // input register
  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_bs_q;

  // pairing state
  phase_e           phase_q;
  logic [WordW-1:0] held_q;

  // result register
  logic             out_valid_q, out_valid_d;
  hit_t             hit_q;

  dec_out_t dec;
  logic     out_free, s1_fire, in_fire;

  wcwd_decode u_decode (
    .word_i       (s1_word_q),
    .block_start_i(s1_bs_q),
    .phase_i      (phase_q),
    .held_i       (held_q),
    .dec_o        (dec)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  // a first word never needs the result register
  assign s1_fire    = s1_valid_q && (!dec.has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && dec.has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      held_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        phase_q <= dec.phase_d;
        held_q  <= dec.held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= data_word_i;
      s1_bs_q   <= block_start_i;
    end
    if (s1_fire && dec.has_result) begin
      hit_q <= dec.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_valid_o = hit_q.valid;
  assign hit_start_o = hit_q.start;
  assign hit_end_o   = hit_q.stop;
  assign status_o    = hit_q.status;

endmodule

### rtl/core/wcwd_checker.sv
// ----------------------------------------------------------------------------
// wcwd_checker
// Port-level checks on the decoder results, bound to the top level.
// ----------------------------------------------------------------------------
module wcwd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_valid_o,
  input logic [wcwd_pkg::WordW-1:0]   hit_start_o,
  input logic [wcwd_pkg::WordW-1:0]   hit_end_o,
  input logic [wcwd_pkg::StatusW-1:0] status_o
);
  import wcwd_pkg::*;

  logic [WordW-1:0] span;
  assign span = hit_end_o - hit_start_o;

  // failed pair carries an empty range
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_valid_o) |-> (hit_start_o == '0 && hit_end_o == '0))
    else $error("failed pair with nonzero range");

  // recorded range only with ok or duplicate warning
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_valid_o) |->
      (status_o == ST_OK || status_o == ST_DUP_MISMATCH))
    else $error("hit recorded with error status");

  // range spans at most the 4-bit width; a duplicate pair spans one wire
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_valid_o) |->
      (span <= 16'd15 && (status_o != ST_DUP_MISMATCH || span == 16'd1)))
    else $error("hit range span out of bounds");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(hit_start_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind wire_chamber_word_decoder wcwd_checker u_wcwd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .hit_valid_o(hit_valid_o),
  .hit_start_o(hit_start_o),
  .hit_end_o  (hit_end_o),
  .status_o   (status_o)
);
